// ----- hw/rtl/sfs_pkg.sv -----
// shared types, constants and the byte-to-level table of the frame slicer
package sfs_pkg;

  localparam int MotorsPerBoard = 9;
  localparam int IdxW = (MotorsPerBoard > 1) ? $clog2(MotorsPerBoard) : 1;

  localparam int MinUs = 1000;
  localparam int MaxUs = 2000;
  localparam int IdleUs = 1000;
  localparam int BaseUs = 1200;
  localparam int SpanUs = 800;

  localparam logic [12:0] IdleLevel = 13'((IdleUs * 75) / 32);

  // configuration register indexes
  typedef enum logic [1:0] {
    RegBoardIndex   = 2'd0,
    RegFrameLength  = 2'd1,
    RegFrameTimeout = 2'd2,
    RegSafetyTimeout = 2'd3
  } cfg_reg_e;

  // input item kinds
  typedef enum logic [1:0] {
    ActByte = 2'd0,
    ActSync = 2'd1,
    ActTick = 2'd2
  } action_e;

  typedef logic [255:0][12:0] level_lut_t;

  // pwm level for each raw byte: pulse width, clamp, then scale by 75/32
  function automatic level_lut_t build_level_lut();
    level_lut_t lut;
    int us;
    for (int i = 0; i < 256; i++) begin
      if (i == 0) us = IdleUs;
      else us = BaseUs + (i * SpanUs) / 255;
      if (us < MinUs) us = MinUs;
      if (us > MaxUs) us = MaxUs;
      lut[i] = 13'((us * 75) / 32);
    end
    return lut;
  endfunction

  localparam level_lut_t LevelLut = build_level_lut();

endpackage

// ----- hw/rtl/spi_frame_slicer_motor_pulse.sv -----
// frame slicer: byte window staging, sync and watchdog runs of motor pwm levels
// results: byte and tick items give no result; a sync or a safety trip gives a
//   run of MotorsPerBoard results, each through StRead (memory read), StConv (level
//   convert) and StEmit (present), held in StEmit until the sink is ready
// throughput: one byte or tick per cycle while no run is in progress; after a run the
//   next item is taken the cycle after the final transfer
// reset: asynchronous active low, registers back to defaults, staging buffer
//   reads as zero through per-entry valid bits, no clearing pass
module spi_frame_slicer_motor_pulse
  import sfs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [3:0] motor_id, [16:4] pwm_level, rest zero
  output logic        m_axis_tlast_o,   // last_motor
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i
);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StConv,
    StEmit
  } state_e;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MotorsPerBoard - 1);
  localparam logic [6:0]      WinLen  = 7'(MotorsPerBoard);

  // configuration registers
  logic [1:0]  board_index_q;
  logic [6:0]  frame_length_q;
  logic [15:0] frame_timeout_q;
  logic [19:0] safety_timeout_q;

  // control state
  state_e          state_q;
  logic [5:0]      byte_pos_q;
  logic [16:0]     tsb_q;
  logic [20:0]     tss_q;
  logic            tripped_q;
  logic            idle_run_q;
  logic [IdxW-1:0] run_idx_q;
  logic [12:0]     out_level_q;
  logic            out_valid_q;

  // staging memory and its valid bits
  logic [7:0]               stage_mem [MotorsPerBoard];
  logic [MotorsPerBoard-1:0] stage_vld_q;
  logic [7:0]               mem_rd_q;
  logic                     rd_vld_q;

  logic        in_xfer;
  logic        out_xfer;
  action_e     action;
  logic [6:0]  win_start;
  logic [6:0]  win_off;
  logic        in_window;
  logic        wr_en;
  logic [IdxW-1:0] wr_idx;
  logic [6:0]  len_eff;
  logic [6:0]  pos_inc;
  logic [5:0]  byte_pos_d;
  logic [16:0] tsb_d;
  logic [20:0] tss_d;
  logic        trip_now;
  logic [7:0]  conv_raw;
  logic [12:0] conv_level;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = m_axis_tvalid_o && m_axis_tready_i;
  assign action          = action_e'(s_axis_tuser_i);

  // window of this board inside the frame
  assign win_start = 7'(board_index_q) * WinLen;
  assign win_off   = {1'b0, byte_pos_q} - win_start;
  assign in_window = ({1'b0, byte_pos_q} >= win_start) && (win_off < WinLen);
  assign wr_idx    = win_off[IdxW-1:0];
  assign wr_en     = in_xfer && (action == ActByte) && in_window;

  // frame length zero acts as one, above 64 acts as 64
  always_comb begin
    if (frame_length_q == 7'd0)       len_eff = 7'd1;
    else if (frame_length_q > 7'd64)  len_eff = 7'd64;
    else                              len_eff = frame_length_q;
  end

  assign pos_inc = {1'b0, byte_pos_q} + 7'd1;
  assign tsb_d   = (tsb_q == '1) ? tsb_q : tsb_q + 17'd1;
  assign tss_d   = (tss_q == '1) ? tss_q : tss_q + 21'd1;
  assign trip_now = (tss_d > {1'b0, safety_timeout_q}) && !tripped_q;

  always_comb begin
    byte_pos_d = byte_pos_q;
    case (action)
      ActByte: byte_pos_d = (pos_inc >= len_eff) ? 6'd0 : pos_inc[5:0];
      ActSync: byte_pos_d = 6'd0;
      ActTick: begin
        // stalled mid-frame: realign to the frame start
        if ((byte_pos_q != 6'd0) && (tsb_d > {1'b0, frame_timeout_q})) byte_pos_d = 6'd0;
      end
      default: byte_pos_d = byte_pos_q;
    endcase
  end

  // level of the entry just read; idle runs ignore the memory
  assign conv_raw   = rd_vld_q ? mem_rd_q : 8'd0;
  assign conv_level = idle_run_q ? IdleLevel : LevelLut[conv_raw];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_index_q    <= 2'd0;
      frame_length_q   <= 7'd36;
      frame_timeout_q  <= 16'd5000;
      safety_timeout_q <= 20'd200000;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        RegBoardIndex:    board_index_q    <= cfg_data_i[1:0];
        RegFrameLength:   frame_length_q   <= cfg_data_i[6:0];
        RegFrameTimeout:  frame_timeout_q  <= cfg_data_i[15:0];
        RegSafetyTimeout: safety_timeout_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // staging memory: one write port from the byte path, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) stage_mem[wr_idx] <= s_axis_tdata_i;
    if (state_q == StRead) mem_rd_q <= stage_mem[run_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      if (wr_en) stage_vld_q[wr_idx] <= 1'b1;
      if (state_q == StRead) rd_vld_q <= stage_vld_q[run_idx_q];
    end
  end

  // sequencer: takes items in idle, walks the motors for a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      byte_pos_q  <= 6'd0;
      tsb_q       <= 17'd0;
      tss_q       <= 21'd0;
      tripped_q   <= 1'b0;
      idle_run_q  <= 1'b0;
      run_idx_q   <= '0;
      out_level_q <= 13'd0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_xfer) begin
            byte_pos_q <= byte_pos_d;
            case (action)
              ActByte: tsb_q <= 17'd0;
              ActSync: begin
                tss_q      <= 21'd0;
                tripped_q  <= 1'b0;
                idle_run_q <= 1'b0;
                run_idx_q  <= '0;
                state_q    <= StRead;
              end
              ActTick: begin
                tsb_q <= tsb_d;
                tss_q <= tss_d;
                if (trip_now) begin
                  tripped_q  <= 1'b1;
                  idle_run_q <= 1'b1;
                  run_idx_q  <= '0;
                  state_q    <= StRead;
                end
              end
              default: ;
            endcase
          end
        end
        StRead: state_q <= StConv;
        StConv: begin
          out_level_q <= conv_level;
          out_valid_q <= 1'b1;
          state_q     <= StEmit;
        end
        StEmit: begin
          if (out_xfer) begin
            out_valid_q <= 1'b0;
            if (run_idx_q == LastIdx) begin
              state_q <= StIdle;
            end else begin
              run_idx_q <= run_idx_q + 1'b1;
              state_q   <= StRead;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_level_q, 4'(run_idx_q)};
  assign m_axis_tlast_o  = (run_idx_q == LastIdx);

  // no new item while a result is on offer
  a_no_accept_during_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input ready while a result is pending");

  // levels stay inside the clamped pulse range
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_level_q >= IdleLevel) && (out_level_q <= 13'd4687))
    else $error("pwm level out of range");

  // a run ends with the final transfer and the block takes input again
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && m_axis_tlast_o) |=> s_axis_tready_o)
    else $error("block not idle after final motor");

  // a sync clears the watchdog and realigns the frame
  a_sync_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action == ActSync) |=> !tripped_q && (byte_pos_q == 6'd0) && (tss_q == 21'd0))
    else $error("sync did not clear watchdog state");

  // the watchdog fires its idle run at most once per loss of sync
  a_trip_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && action == ActTick && tripped_q) |=> (state_q == StIdle))
    else $error("idle run repeated without a sync");

endmodule

// ----- tb/tb_spi_frame_slicer_motor_pulse.sv -----
// self-checking testbench of the frame slicer: directed table, then random frames, syncs and ticks
module tb_spi_frame_slicer_motor_pulse;
  timeunit 1ns;
  timeprecision 1ps;
  import sfs_pkg::*;

  // action code the block must ignore
  localparam logic [1:0] ActUnused = 2'd3;
  // byte and tick items give no result, so a short settle covers them
  localparam int SettleCycles = 4;
  localparam int CycleLimit = 1_000_000;
  localparam int RandomItems = 400;
  localparam int NoLevel = -1;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;    // [7:0] data_byte
  logic [1:0]  s_axis_tuser_i = '0;    // [1:0] action
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;         // [3:0] motor_id, [16:4] pwm_level, [23:17] zero
  logic        m_axis_tlast_o;         // last_motor
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [19:0] cfg_data_i = '0;

  spi_frame_slicer_motor_pulse dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // one expected motor result
  typedef struct packed {
    logic [3:0]  motor;
    logic [12:0] level;
    logic        last;
  } motor_level_t;

  // directed stimulus: either a register write or an input item, with the
  // level of motor 0 typed in where it is obvious (reset, full scale, idle)
  typedef enum bit {RowItem, RowCfg} row_kind_e;
  typedef struct packed {
    row_kind_e   kind;
    cfg_reg_e    sel;
    logic [19:0] val;
    logic [1:0]  act;
    logic [7:0]  data;
    int          lvl0;
  } stim_row_t;

  localparam int DirRows = 31;
  localparam stim_row_t DirTab [DirRows] = '{
    // staging buffer reads zero after reset, so every motor idles
    '{RowItem, RegBoardIndex,    20'h00000, ActSync,   8'h00, 2343},
    // fill the whole window of board 0 with bit patterns and extremes
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'hFF, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h01, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h80, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h55, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'hAA, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h0F, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'hF0, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h7F, NoLevel},
    // first byte past the window is dropped
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'hFE, NoLevel},
    // unused action code leaves everything alone
    '{RowItem, RegBoardIndex,    20'h00000, ActUnused, 8'hFF, NoLevel},
    // raw 255 is the 2000 us ceiling
    '{RowItem, RegBoardIndex,    20'h00000, ActSync,   8'h00, 4687},
    // zero safety timeout trips on the first tick, and only once
    '{RowCfg,  RegSafetyTimeout, 20'h00000, ActTick,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActTick,   8'h00, 2343},
    '{RowItem, RegBoardIndex,    20'h00000, ActTick,   8'h00, NoLevel},
    // zero frame timeout realigns on the first tick mid-frame
    '{RowCfg,  RegFrameTimeout,  20'h00000, ActTick,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h33, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActTick,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActSync,   8'h00, NoLevel},
    // timeouts at their largest, frame length zero keeps position at zero
    '{RowCfg,  RegSafetyTimeout, 20'hFFFFF, ActTick,   8'h00, NoLevel},
    '{RowCfg,  RegFrameTimeout,  20'h0FFFF, ActTick,   8'h00, NoLevel},
    '{RowCfg,  RegFrameLength,   20'h00000, ActTick,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h12, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActSync,   8'h00, 2343},
    // last board, frame length above 64 acts as 64
    '{RowCfg,  RegBoardIndex,    20'h00003, ActTick,   8'h00, NoLevel},
    '{RowCfg,  RegFrameLength,   20'h0007F, ActTick,   8'h00, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'hC3, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActByte,   8'h3C, NoLevel},
    '{RowItem, RegBoardIndex,    20'h00000, ActSync,   8'h00, NoLevel}
  };

  motor_level_t level_q[$];    // motor levels still owed by the block
  int err_cnt = 0;
  int sent_cnt = 0;            // accepted items other than the unused code
  int burst_left = 0;
  int cyc = 0;
  int sink_cnt = 0;
  int sink_mode = 0;

  // shadow of the slicer: registers and state
  logic [1:0]  board_r;
  logic [6:0]  flen_r;
  logic [15:0] ftmo_r;
  logic [19:0] stmo_r;
  logic [5:0]  pos_r;
  logic [7:0]  stage_r [MotorsPerBoard];
  logic [16:0] tsb_r;
  logic [20:0] tss_r;
  bit          tripped_r;

  // pulse width of a raw byte, zero means idle
  function automatic int raw_width_us(logic [7:0] raw);
    if (raw == 8'd0) return 1000;
    return 1200 + (int'(raw) * 800) / 255;
  endfunction

  // clamp to 1000..2000 us, then scale by 75/32
  function automatic logic [12:0] pwm_from_width(int us);
    if (us < 1000) us = 1000;
    if (us > 2000) us = 2000;
    return 13'((us * 75) / 32);
  endfunction

  // effective frame length: zero acts as one, the position is only six bits
  function automatic int frame_bytes();
    int n;
    n = int'(flen_r);
    if (n == 0) n = 1;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // owe one full run of motor levels, from the staging bytes or idle
  task automatic queue_motor_run(bit idle);
    motor_level_t m;
    for (int k = 0; k < MotorsPerBoard; k++) begin
      m.motor = 4'(k);
      m.level = pwm_from_width(idle ? 1000 : raw_width_us(stage_r[k]));
      m.last = (k == MotorsPerBoard - 1);
      level_q.push_back(m);
    end
  endtask

  // advance the shadow by one accepted item
  task automatic slicer_step(logic [1:0] act, logic [7:0] d);
    int start;
    int nxt;
    start = int'(board_r) * MotorsPerBoard;
    case (act)
      ActByte: begin
        if (int'(pos_r) >= start && int'(pos_r) < start + MotorsPerBoard)
          stage_r[int'(pos_r) - start] = d;
        nxt = int'(pos_r) + 1;
        if (nxt >= frame_bytes()) nxt = 0;
        pos_r = 6'(nxt);
        tsb_r = '0;
      end
      ActSync: begin
        pos_r = '0;
        tss_r = '0;
        tripped_r = 1'b0;
        queue_motor_run(1'b0);
      end
      ActTick: begin
        if (tsb_r != '1) tsb_r = tsb_r + 1'b1;
        if (tss_r != '1) tss_r = tss_r + 1'b1;
        if (pos_r != '0 && int'(tsb_r) > int'(ftmo_r)) pos_r = '0;
        // idle run only once per loss of sync
        if (int'(tss_r) > int'(stmo_r) && !tripped_r) begin
          tripped_r = 1'b1;
          queue_motor_run(1'b1);
        end
      end
      default: ;
    endcase
  endtask

  // one input transfer, opening a new burst after a random gap when due
  task automatic send_item(logic [1:0] act, logic [7:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= act;
    s_axis_tdata_i <= d;
    do @(posedge clk_i); while (!s_axis_tready_o);
    slicer_step(act, d);
    if (act != ActUnused) sent_cnt++;
  endtask

  // stop sending, wait for every owed level, then let trailing items settle
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // valid stays high across back-to-back writes; the caller drops it
  task automatic write_reg(cfg_reg_e sel, logic [19:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (sel)
      RegBoardIndex:    board_r = v[1:0];
      RegFrameLength:   flen_r = v[6:0];
      RegFrameTimeout:  ftmo_r = v[15:0];
      RegSafetyTimeout: stmo_r = v;
      default: ;
    endcase
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk_i) begin : sink
    motor_level_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (level_q.size() == 0) begin
        $error("unexpected transfer: motor_id %0d pwm_level %0d",
               m_axis_tdata_o[3:0], m_axis_tdata_o[16:4]);
        err_cnt++;
      end else begin
        e = level_q.pop_front();
        if (m_axis_tdata_o[3:0] != e.motor) begin
          $error("motor_id: expected %0d, got %0d", e.motor, m_axis_tdata_o[3:0]);
          err_cnt++;
        end
        if (m_axis_tdata_o[16:4] != e.level) begin
          $error("pwm_level: expected %0d, got %0d", e.level, m_axis_tdata_o[16:4]);
          err_cnt++;
        end
        if (m_axis_tlast_o != e.last) begin
          $error("last_motor: expected %0d, got %0d", e.last, m_axis_tlast_o);
          err_cnt++;
        end
        if (m_axis_tdata_o[23:17] != '0) begin
          $error("tdata pad: expected 0, got %0d", m_axis_tdata_o[23:17]);
          err_cnt++;
        end
      end
    end
    // stall pattern is redrawn at random: open, coin flip, sparse, alternating blocks
    sink_cnt++;
    if (sink_cnt % 50 == 0) sink_mode = $urandom_range(0, 3);
    case (sink_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= 1'($urandom_range(0, 1));
      2: m_axis_tready_i <= (sink_cnt % 5 == 0);
      default: m_axis_tready_i <= ((sink_cnt / 8) % 2 == 0);
    endcase
  end

  // hang guard
  always @(posedge clk_i) begin
    cyc++;
    if (cyc >= CycleLimit) begin
      $display("spi_frame_slicer_motor_pulse: mismatch");
      $finish;
    end
  end

  initial begin : stim
    stim_row_t row;
    bit in_cfg;
    int base;
    int stop;
    int bi;
    int fl;
    int len;
    int n;
    int r;

    // shadow starts at the reset defaults
    board_r = 2'd0;
    flen_r = 7'd36;
    ftmo_r = 16'd5000;
    stmo_r = 20'd200000;
    pos_r = '0;
    for (int k = 0; k < MotorsPerBoard; k++) stage_r[k] = '0;
    tsb_r = '0;
    tss_r = '0;
    tripped_r = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    in_cfg = 1'b0;
    for (int i = 0; i < DirRows; i++) begin
      row = DirTab[i];
      if (row.kind == RowCfg) begin
        if (!in_cfg) drain_results();
        in_cfg = 1'b1;
        write_reg(row.sel, row.val);
      end else begin
        if (in_cfg) cfg_valid_i <= 1'b0;
        in_cfg = 1'b0;
        send_item(row.act, row.data);
        // typed level replaces the shadow's value for motor 0 of this run
        if (row.lvl0 != NoLevel)
          level_q[level_q.size() - MotorsPerBoard].level = 13'(row.lvl0);
      end
    end

    // random phases: fresh settings, then a mix of frames, tick runs,
    // broken frames and raw noise
    base = sent_cnt;
    while (sent_cnt - base < RandomItems) begin
      drain_results();
      bi = $urandom_range(0, 3);
      r = $urandom_range(0, 9);
      if (r < 4) fl = bi * MotorsPerBoard + $urandom_range(MotorsPerBoard, MotorsPerBoard + 6);
      else if (r < 7) fl = $urandom_range(1, 20);
      else if (r < 9) fl = $urandom_range(21, 64);
      else fl = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(65, 127);
      // upper data bits are don't-care for the narrow registers
      write_reg(RegBoardIndex, {18'($urandom), 2'(bi)});
      write_reg(RegFrameLength, {13'($urandom), 7'(fl)});
      if ($urandom_range(0, 7) == 0) write_reg(RegFrameTimeout, 20'($urandom));
      else write_reg(RegFrameTimeout, {4'($urandom), 16'($urandom_range(0, 12))});
      if ($urandom_range(0, 7) == 0) write_reg(RegSafetyTimeout, 20'($urandom));
      else write_reg(RegSafetyTimeout, 20'($urandom_range(0, 80)));
      cfg_valid_i <= 1'b0;

      stop = sent_cnt + $urandom_range(30, 90);
      while (sent_cnt < stop) begin
        len = frame_bytes();
        r = $urandom_range(0, 99);
        if (r < 50) begin
          // whole frame with a stray tick now and then, closed by a sync
          for (int b = 0; b < len; b++) begin
            if ($urandom_range(0, 7) == 0) send_item(ActTick, pick_byte());
            send_item(ActByte, pick_byte());
          end
          send_item(ActSync, pick_byte());
        end else if (r < 70) begin
          // tick run, long enough to hit the watchdog at small timeouts
          n = $urandom_range(1, 60);
          repeat (n) send_item(ActTick, pick_byte());
        end else if (r < 85) begin
          // frame cut short, then idle ticks toward the stall realign
          n = $urandom_range(1, len);
          repeat (n) send_item(ActByte, pick_byte());
          n = $urandom_range(0, 20);
          repeat (n) send_item(ActTick, pick_byte());
        end else begin
          n = $urandom_range(1, 5);
          repeat (n) send_item(2'($urandom_range(0, 3)), pick_byte());
        end
      end
    end

    drain_results();
    if (err_cnt == 0) begin
      $display("spi_frame_slicer_motor_pulse: match");
    end else begin
      $display("spi_frame_slicer_motor_pulse: mismatch");
    end
    $finish;
  end

endmodule

// ----- spi_frame_slicer_motor_pulse.f -----
hw/rtl/sfs_pkg.sv
hw/rtl/spi_frame_slicer_motor_pulse.sv
tb/tb_spi_frame_slicer_motor_pulse.sv
